// ===== rtl/core/tsc_pkg.sv =====
package tsc_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned LengthW   = 25;
  localparam int unsigned WordW     = 16;
  localparam int unsigned PayloadW  = 10;
  localparam int unsigned ErrCodeW  = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned RetryW    = 17;
  localparam int unsigned CfgIndexW = 1;

  typedef enum logic [CmdW-1:0] {
    CmdStart  = 2'd0,
    CmdPacket = 2'd1,
    CmdTick   = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ActNone  = 2'd0,
    ActData  = 2'd1,
    ActAck   = 2'd2,
    ActError = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StBusy        = 3'd0,
    StDone        = 3'd1,
    StServerError = 3'd2,
    StTimeout     = 3'd3,
    StRetryLimit  = 3'd4,
    StOutOfFile   = 3'd5
  } status_e;

  typedef enum logic {
    PhIdle   = 1'b0,
    PhActive = 1'b1
  } phase_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgMaxRetrans = 1'b0,
    CfgTimeout    = 1'b1
  } cfg_index_e;

  localparam logic [WordW-1:0] OpData  = 16'd3;
  localparam logic [WordW-1:0] OpAck   = 16'd4;
  localparam logic [WordW-1:0] OpError = 16'd5;

  localparam logic [ErrCodeW-1:0] ErrUndefined = 3'd0;
  localparam logic [ErrCodeW-1:0] ErrAccess    = 3'd2;
  localparam logic [ErrCodeW-1:0] ErrBadOp     = 3'd4;
  localparam logic [ErrCodeW-1:0] ErrBadId     = 3'd5;

  localparam logic [WordW-1:0] TimeoutReset = 16'd5;

  typedef struct packed {
    cmd_e               cmd;
    logic [LengthW-1:0] file_length;
    logic [WordW-1:0]   packet_opcode;
    logic [WordW-1:0]   packet_number;
  } item_t;

  typedef struct packed {
    action_e             action;
    logic [WordW-1:0]    block_number;
    logic [LengthW-1:0]  byte_offset;
    logic [PayloadW-1:0] payload_length;
    logic [ErrCodeW-1:0] sent_error_code;
    status_e             status;
    logic [WordW-1:0]    server_error;
  } result_t;

endpackage

// ===== rtl/core/tftp_send_transfer_control.sv =====
// Sender side of a TFTP write transfer. Each item (start, received packet header or
// one-second tick) yields exactly one result item: a DATA, ACK or ERROR send order, or
// nothing, with the transfer status. One item can be accepted every clock cycle while
// the output is not stalled; an item passes from acceptance to its result through an
// input register, one pass of the decision logic (one small constant multiply for the
// byte offset) and the result register. Configuration writes are always ready and must
// be made while no item is in flight.
module tftp_send_transfer_control #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tsc_pkg::CmdW-1:0]              cmd_i,
  input  logic [tsc_pkg::LengthW-1:0]           file_length_i,
  input  logic [tsc_pkg::WordW-1:0]             packet_opcode_i,
  input  logic [tsc_pkg::WordW-1:0]             packet_number_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            action_o,
  output logic [tsc_pkg::WordW-1:0]             block_number_o,
  output logic [tsc_pkg::LengthW-1:0]           byte_offset_o,
  output logic [tsc_pkg::PayloadW-1:0]          payload_length_o,
  output logic [tsc_pkg::ErrCodeW-1:0]          sent_error_code_o,
  output logic [tsc_pkg::StatusW-1:0]           status_o,
  output logic [tsc_pkg::WordW-1:0]             server_error_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tsc_pkg::CfgIndexW-1:0]         cfg_index_i,
  input  logic [tsc_pkg::WordW-1:0]             cfg_data_i
);

  tsc_pkg::item_t            in_item;
  tsc_pkg::item_t            item;
  tsc_pkg::result_t          res;
  tsc_pkg::result_t          res_q;
  logic                      item_valid;
  logic                      out_valid;
  logic                      take;
  logic [tsc_pkg::WordW-1:0] max_retrans_q;
  logic [tsc_pkg::WordW-1:0] timeout_q;
  logic                      cfg_we;

  assign in_item.cmd           = tsc_pkg::cmd_e'(cmd_i);
  assign in_item.file_length   = file_length_i;
  assign in_item.packet_opcode = packet_opcode_i;
  assign in_item.packet_number = packet_number_i;

  assign take = item_valid && (!out_valid || !out_stall_i);

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retrans_q <= '0;
      timeout_q     <= tsc_pkg::TimeoutReset;
    end else if (cfg_we) begin
      case (cfg_index_i)
        tsc_pkg::CfgMaxRetrans: max_retrans_q <= cfg_data_i;
        tsc_pkg::CfgTimeout:    timeout_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  tsc_core #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .item_i        (item),
    .max_retrans_i (max_retrans_q),
    .timeout_i     (timeout_q),
    .result_o      (res)
  );

  tsc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .result_i    (res),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall_i),
    .result_o    (res_q)
  );

  assign out_valid_o       = out_valid;
  assign action_o          = res_q.action;
  assign block_number_o    = res_q.block_number;
  assign byte_offset_o     = res_q.byte_offset;
  assign payload_length_o  = res_q.payload_length;
  assign sent_error_code_o = res_q.sent_error_code;
  assign status_o          = res_q.status;
  assign server_error_o    = res_q.server_error;

endmodule

// ===== rtl/core/tsc_in_reg.sv =====
module tsc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tsc_pkg::item_t in_item_i,
  input  logic           take_i,
  output logic           valid_o,
  output tsc_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  tsc_pkg::item_t item_q;
  logic           load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/tsc_core.sv =====
module tsc_core #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  tsc_pkg::item_t                 item_i,
  input  logic [tsc_pkg::WordW-1:0]      max_retrans_i,
  input  logic [tsc_pkg::WordW-1:0]      timeout_i,
  output tsc_pkg::result_t               result_o
);

  localparam int unsigned BbW = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned SW  = tsc_pkg::WordW + BbW;
  localparam int unsigned XW  = (SW > tsc_pkg::LengthW) ? SW : tsc_pkg::LengthW;
  localparam logic [XW-1:0] BbConst = XW'(BLOCK_BYTES);

  tsc_pkg::phase_e                phase_q, phase_d;
  logic [tsc_pkg::WordW-1:0]      last_q, last_d;
  logic [tsc_pkg::WordW-1:0]      bpos_q, bpos_d;
  logic [tsc_pkg::RetryW-1:0]     retry_q, retry_d;
  logic                           first_q, first_d;
  logic                           end_q, end_d;
  logic [tsc_pkg::LengthW-1:0]    len_q, len_d;
  logic [tsc_pkg::WordW-1:0]      idle_q, idle_d;
  logic [tsc_pkg::WordW-1:0]      ssv_q, ssv_d;

  logic [XW-1:0]                  prod;
  logic [XW-1:0]                  start;
  logic [XW-1:0]                  len_w;
  logic [XW-1:0]                  rem;
  logic [XW-1:0]                  plen;
  logic [tsc_pkg::WordW-1:0]      idle_inc;
  logic [tsc_pkg::WordW-1:0]      ssv_inc;
  logic [tsc_pkg::RetryW-1:0]     retry_inc;
  logic                           in_order;
  logic                           advance;
  logic                           send;
  tsc_pkg::result_t               res;

  assign in_order  = ((last_q + 16'd1) == item_i.packet_number);
  assign advance   = in_order && !end_q;
  assign prod      = XW'(bpos_q) * BbConst;
  assign start     = advance ? ((bpos_q == '1) ? '0 : prod + BbConst) : prod;
  assign len_w     = XW'(len_q);
  assign rem       = len_w - start;
  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + 16'd1;
  assign ssv_inc   = (ssv_q == '1) ? ssv_q : ssv_q + 16'd1;
  assign retry_inc = (retry_q == '1) ? retry_q : retry_q + 17'd1;

  always_comb begin
    phase_d = phase_q;
    last_d  = last_q;
    bpos_d  = bpos_q;
    retry_d = retry_q;
    first_d = first_q;
    end_d   = end_q;
    len_d   = len_q;
    idle_d  = idle_q;
    ssv_d   = ssv_q;
    res     = '0;
    send    = 1'b0;
    plen    = '0;

    if (item_i.cmd == tsc_pkg::CmdStart) begin
      last_d  = '0;
      bpos_d  = '0;
      retry_d = '0;
      first_d = 1'b0;
      end_d   = 1'b0;
      idle_d  = '0;
      ssv_d   = '0;
      len_d   = item_i.file_length;
      phase_d = tsc_pkg::PhActive;
    end else if (phase_q != tsc_pkg::PhActive || item_i.cmd == tsc_pkg::CmdNone) begin
      res = '0;
    end else if (item_i.cmd == tsc_pkg::CmdTick) begin
      idle_d = idle_inc;
      ssv_d  = ssv_inc;
      if (timeout_i != '0 && idle_inc >= timeout_i) begin
        res.action          = tsc_pkg::ActError;
        res.sent_error_code = tsc_pkg::ErrUndefined;
        res.status          = tsc_pkg::StTimeout;
        phase_d             = tsc_pkg::PhIdle;
      end
    end else begin
      idle_d = '0;
      if (item_i.packet_opcode == tsc_pkg::OpError) begin
        res.status       = tsc_pkg::StServerError;
        res.server_error = item_i.packet_number;
        phase_d          = tsc_pkg::PhIdle;
      end else if (item_i.packet_opcode == tsc_pkg::OpAck) begin
        if (in_order) begin
          last_d  = item_i.packet_number;
          retry_d = '0;
          if (!end_q) begin
            bpos_d = bpos_q + 16'd1;
            send   = 1'b1;
          end else begin
            res.action       = tsc_pkg::ActAck;
            res.block_number = item_i.packet_number;
            res.status       = tsc_pkg::StDone;
            phase_d          = tsc_pkg::PhIdle;
          end
        end else if (first_q) begin
          retry_d = retry_inc;
          if (max_retrans_i != '0 && retry_inc > tsc_pkg::RetryW'(max_retrans_i)) begin
            res.action          = tsc_pkg::ActError;
            res.sent_error_code = tsc_pkg::ErrBadOp;
            res.status          = tsc_pkg::StRetryLimit;
            phase_d             = tsc_pkg::PhIdle;
          end else if (item_i.packet_number == last_q) begin
            send = 1'b1;
          end
        end else begin
          send = 1'b1;
        end

        if (send) begin
          first_d = 1'b1;
          if (len_w > start) begin
            plen  = (rem > BbConst) ? BbConst : rem;
            end_d = (rem < BbConst);
          end else if (len_w == start) begin
            plen  = '0;
            end_d = 1'b1;
          end else begin
            send = 1'b0;
            res.action          = tsc_pkg::ActError;
            res.sent_error_code = tsc_pkg::ErrAccess;
            res.status          = tsc_pkg::StOutOfFile;
            phase_d             = tsc_pkg::PhIdle;
          end
          if (send) begin
            ssv_d              = '0;
            res.action         = tsc_pkg::ActData;
            res.block_number   = last_d + 16'd1;
            res.byte_offset    = start[tsc_pkg::LengthW-1:0];
            res.payload_length = plen[tsc_pkg::PayloadW-1:0];
          end
        end
      end else if (ssv_q > timeout_i) begin
        res.action          = tsc_pkg::ActError;
        res.sent_error_code = (item_i.packet_opcode == tsc_pkg::OpData) ?
                              tsc_pkg::ErrBadId : tsc_pkg::ErrBadOp;
        res.status          = tsc_pkg::StTimeout;
        phase_d             = tsc_pkg::PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tsc_pkg::PhIdle;
      last_q  <= '0;
      bpos_q  <= '0;
      retry_q <= '0;
      first_q <= 1'b0;
      end_q   <= 1'b0;
      len_q   <= '0;
      idle_q  <= '0;
      ssv_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      last_q  <= last_d;
      bpos_q  <= bpos_d;
      retry_q <= retry_d;
      first_q <= first_d;
      end_q   <= end_d;
      len_q   <= len_d;
      idle_q  <= idle_d;
      ssv_q   <= ssv_d;
    end
  end

  assign result_o = res;

endmodule

// ===== rtl/core/tsc_out_reg.sv =====
module tsc_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  tsc_pkg::result_t result_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tsc_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  tsc_pkg::result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
